FILE: rtl/legv8_subset_execute_top_macros.svh
// Assertion macros shared by the execute block.
`ifndef LEGV8_SUBSET_EXECUTE_TOP_MACROS_SVH
`define LEGV8_SUBSET_EXECUTE_TOP_MACROS_SVH

// Check an implication that holds in the same cycle.
`define LSE_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check an implication whose consequence holds in the next cycle.
`define LSE_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/lse_pkg.sv
// Shared constants, types and the opcode decoder of the execute block.
`default_nettype none

package lse_pkg;

  localparam int NUM_REGS   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int REG_AW     = $clog2(NUM_REGS);
  localparam int INDEX_W    = 32;
  localparam int KIND_W     = 5;

  localparam logic [10:0] OP11_ADD  = 11'b10001011000;
  localparam logic [10:0] OP11_AND  = 11'b10001010000;
  localparam logic [10:0] OP11_EOR  = 11'b11001010000;
  localparam logic [10:0] OP11_SUB  = 11'b11001011000;
  localparam logic [10:0] OP11_STUR = 11'b11111000000;
  localparam logic [10:0] OP11_LDUR = 11'b11111000010;
  localparam logic [10:0] OP11_LSL  = 11'b11010011011;
  localparam logic [10:0] OP11_LSR  = 11'b11010011010;
  localparam logic [10:0] OP11_BR   = 11'b11010110000;
  localparam logic [10:0] OP11_SUBS = 11'b11101011000;
  localparam logic [10:0] OP11_MUL  = 11'b10011011000;

  localparam logic [9:0] OP10_ADDI  = 10'b1001000100;
  localparam logic [9:0] OP10_SUBI  = 10'b1101000100;
  localparam logic [9:0] OP10_ANDI  = 10'b1001001000;
  localparam logic [9:0] OP10_ORRI  = 10'b1011001000;
  localparam logic [9:0] OP10_SUBIS = 10'b1111000100;

  typedef enum logic [KIND_W-1:0] {
    K_UNKNOWN = 5'd0,
    K_ADD     = 5'd1,
    K_AND     = 5'd2,
    K_EOR     = 5'd3,
    K_SUB     = 5'd4,
    K_LSL     = 5'd5,
    K_LSR     = 5'd6,
    K_BR      = 5'd7,
    K_SUBS    = 5'd8,
    K_MUL     = 5'd9,
    K_ADDI    = 5'd10,
    K_SUBI    = 5'd11,
    K_ANDI    = 5'd12,
    K_ORRI    = 5'd13,
    K_SUBIS   = 5'd14,
    K_STUR    = 5'd15,
    K_LDUR    = 5'd16
  } kind_t;

  // Everything one executed instruction produces.
  typedef struct packed {
    kind_t                  kind;
    logic                   write;
    logic [REG_AW-1:0]      dest;
    logic [DATA_WIDTH-1:0]  value;
    logic                   set_flags;
    logic                   neg;
    logic                   zero;
    logic                   branch;
    logic [INDEX_W-1:0]     next;
  } exec_result_t;

  // Try the 11-bit opcode first, then fall back to the 10-bit one.
  function automatic kind_t decode_kind(input logic [31:0] word);
    kind_t k;
    k = K_UNKNOWN;
    unique case (word[31:21])
      OP11_ADD:  k = K_ADD;
      OP11_AND:  k = K_AND;
      OP11_EOR:  k = K_EOR;
      OP11_SUB:  k = K_SUB;
      OP11_STUR: k = K_STUR;
      OP11_LDUR: k = K_LDUR;
      OP11_LSL:  k = K_LSL;
      OP11_LSR:  k = K_LSR;
      OP11_BR:   k = K_BR;
      OP11_SUBS: k = K_SUBS;
      OP11_MUL:  k = K_MUL;
      default: begin
        unique case (word[31:22])
          OP10_ADDI:  k = K_ADDI;
          OP10_SUBI:  k = K_SUBI;
          OP10_ANDI:  k = K_ANDI;
          OP10_ORRI:  k = K_ORRI;
          OP10_SUBIS: k = K_SUBIS;
          default:    k = K_UNKNOWN;
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lse_regfile.sv
// Register file: synchronous memory with valid bits and write-back forwarding.
`default_nettype none

module lse_regfile
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [REG_AW-1:0]     rd_addr_a,
  input  wire logic [REG_AW-1:0]     rd_addr_b,
  input  wire logic                  wr_en,
  input  wire logic [REG_AW-1:0]     wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  output logic      [DATA_WIDTH-1:0] rd_data_a,
  output logic      [DATA_WIDTH-1:0] rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   written;

  logic [DATA_WIDTH-1:0] mem_q_a;
  logic [DATA_WIDTH-1:0] mem_q_b;
  logic                  live_a;
  logic                  live_b;
  logic [REG_AW-1:0]     addr_q_a;
  logic [REG_AW-1:0]     addr_q_b;

  // Last write, kept to cover a read taken on the same edge as that write.
  logic                  wb_valid;
  logic [REG_AW-1:0]     wb_addr;
  logic [DATA_WIDTH-1:0] wb_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_a <= mem[rd_addr_a];
      mem_q_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      wb_valid <= 1'b0;
      live_a   <= 1'b0;
      live_b   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
        wb_valid         <= 1'b1;
      end
      if (rd_en) begin
        live_a <= written[rd_addr_a];
        live_b <= written[rd_addr_b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr <= wr_addr;
      wb_data <= wr_data;
    end
    if (rd_en) begin
      addr_q_a <= rd_addr_a;
      addr_q_b <= rd_addr_b;
    end
  end

  always_comb begin
    if (wb_valid && (wb_addr == addr_q_a)) begin
      rd_data_a = wb_data;
    end else begin
      rd_data_a = live_a ? mem_q_a : '0;
    end
    if (wb_valid && (wb_addr == addr_q_b)) begin
      rd_data_b = wb_data;
    end else begin
      rd_data_b = live_b ? mem_q_b : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lse_alu.sv
// Execute logic: decode one instruction and compute its write-back, flags and next index.
`default_nettype none

module lse_alu
  import lse_pkg::*;
(
  input  wire logic [31:0]           word,
  input  wire logic [DATA_WIDTH-1:0] op_a,
  input  wire logic [DATA_WIDTH-1:0] op_b,
  input  wire logic [INDEX_W-1:0]    prog_index,
  input  wire logic                  neg_flag,
  input  wire logic                  zero_flag,
  output exec_result_t               res
);

  kind_t                   kind;
  logic [5:0]              shamt;
  logic                    shift_out;
  logic [DATA_WIDTH-1:0]   imm;
  logic [2*DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0]   v;
  logic                    write;
  logic                    set_flags;

  assign kind      = decode_kind(word);
  assign shamt     = word[15:10];
  assign shift_out = ({1'b0, shamt} >= 7'(DATA_WIDTH));
  assign imm       = {{(DATA_WIDTH-12){1'b0}}, word[21:10]};
  assign prod      = op_a * op_b;

  always_comb begin
    v         = '0;
    write     = 1'b1;
    set_flags = 1'b0;
    unique case (kind)
      K_ADD:   v = op_a + op_b;
      K_AND:   v = op_a & op_b;
      K_EOR:   v = op_a ^ op_b;
      K_SUB:   v = op_a - op_b;
      K_SUBS: begin
        v         = op_a - op_b;
        set_flags = 1'b1;
      end
      K_MUL:   v = prod[DATA_WIDTH-1:0];
      K_LSL:   v = shift_out ? '0 : (op_a << shamt);
      K_LSR:   v = shift_out ? '0 : (op_a >> shamt);
      K_ADDI:  v = op_a + imm;
      K_SUBI:  v = op_a - imm;
      K_ANDI:  v = op_a & imm;
      K_ORRI:  v = op_a | imm;
      K_SUBIS: begin
        v         = op_a - imm;
        set_flags = 1'b1;
      end
      default: write = 1'b0;
    endcase
  end

  always_comb begin
    res           = '0;
    res.kind      = kind;
    res.write     = write;
    res.dest      = write ? word[REG_AW-1:0] : '0;
    res.value     = write ? v : '0;
    res.set_flags = set_flags;
    res.neg       = set_flags ? v[DATA_WIDTH-1] : neg_flag;
    res.zero      = set_flags ? (v == '0) : zero_flag;
    res.branch    = (kind == K_BR);
    res.next      = (kind == K_BR) ? op_a[INDEX_W-1:0] : prog_index + INDEX_W'(1);
  end

endmodule

`default_nettype wire

FILE: rtl/legv8_subset_execute_top.sv
// Top level of the LEGv8 subset execute block.
// Requests pass the execute stage and then the output register, one per cycle while
//   result_stall is low; the register file is read on the accept edge and
//   written in the execute cycle, with the last write forwarded to the following read.
// Reset: rst clears the pipeline valids, program index, flags and the register valid
//   bits, so every register reads as zero at once; no clearing pass is needed.
`default_nettype none

`include "legv8_subset_execute_top_macros.svh"

module legv8_subset_execute_top
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  instr_valid,
  output logic                       instr_stall,
  input  wire logic [31:0]           instr_word,
  // result channel
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [KIND_W-1:0]          instr_kind,
  output logic                       wrote_reg,
  output logic [REG_AW-1:0]          dest_index,
  output logic [31:0]                dest_value,
  output logic                       neg_out,
  output logic                       zero_out,
  output logic                       branched,
  output logic [INDEX_W-1:0]         next_index
);

  // Execute stage: holds the request while its operands come out of the register file.
  logic        s1_valid;
  logic [31:0] s1_word;
  logic        s1_fire;
  logic        accept;

  // Architectural state kept in flops.
  logic [INDEX_W-1:0] prog_index;
  logic               neg_flag;
  logic               zero_flag;

  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  exec_result_t          res;

  // Advance the execute stage whenever the output register is free or draining.
  assign s1_fire     = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = s1_valid && !s1_fire;
  assign accept      = instr_valid && !instr_stall;

  // Register file: read Rn and Rm on the accept edge, write back on the execute edge.
  lse_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (instr_word[9:5]),
    .rd_addr_b (instr_word[20:16]),
    .wr_en     (s1_fire && res.write),
    .wr_addr   (res.dest),
    .wr_data   (res.value),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  lse_alu u_alu (
    .word       (s1_word),
    .op_a       (op_a),
    .op_b       (op_b),
    .prog_index (prog_index),
    .neg_flag   (neg_flag),
    .zero_flag  (zero_flag),
    .res        (res)
  );

  // Control state: pipeline valids, program index and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      prog_index   <= '0;
      neg_flag     <= 1'b0;
      zero_flag    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        result_valid <= 1'b1;
        prog_index   <= res.next;
        neg_flag     <= res.neg;
        zero_flag    <= res.zero;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload: capture the request word, then the finished result.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= instr_word;
    end
    if (s1_fire) begin
      instr_kind <= res.kind;
      wrote_reg  <= res.write;
      dest_index <= res.dest;
      dest_value <= res.value[31:0];
      neg_out    <= res.neg;
      zero_out   <= res.zero;
      branched   <= res.branch;
      next_index <= res.next;
    end
  end

  // A retired instruction always lands in the output register.
  `LSE_ASSERT_NEXT(a_fire_fills_out, s1_fire, result_valid, "execute did not fill the output")
  // The program index always matches the last reported next index.
  `LSE_ASSERT_NEXT(a_index_tracks, s1_fire, prog_index == next_index, "program index diverged")
  // A branch never writes a register.
  `LSE_ASSERT_NOW(a_br_no_write, result_valid && branched, !wrote_reg, "branch wrote a register")
  // Only SUBS and SUBIS may move the flags.
  `LSE_ASSERT_NEXT(a_flags_hold, s1_fire && !res.set_flags,
    neg_flag == $past(neg_flag) && zero_flag == $past(zero_flag), "flags moved")

endmodule

`default_nettype wire
